// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the integer list checker.
// The macros sample on clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition now implies a consequence in the next cycle
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ilpv_pkg.sv =====
// Package for the integer list checker: sizes, op codes and status codes.
// Used by int_list_parse_validate; depends on nothing.
package ilpv_pkg;

  // Table size and derived widths
  localparam int MAX_NUMBERS = 512;
  localparam int IDX_W       = $clog2(MAX_NUMBERS);
  localparam int CNT_W       = $clog2(MAX_NUMBERS + 1);
  localparam int POS_W       = 10;
  localparam int MAG_W       = 33;
  localparam int VAL_W       = 32;
  localparam int STAT_W      = 3;
  localparam int OP_W        = 2;
  localparam int CH_W        = 8;
  localparam int OUT_DATA_W  = 48;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  // Op codes carried on the input tuser
  localparam op_t OP_CHAR = 2'd0;
  localparam op_t OP_END  = 2'd1;
  localparam op_t OP_LAST = 2'd2;

  // Status codes carried on the output tuser
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_BAD   = 3'd1;
  localparam status_t ST_RANGE = 3'd2;
  localparam status_t ST_DUP   = 3'd3;
  localparam status_t ST_FULL  = 3'd4;

  // Character and range constants
  localparam logic [CH_W-1:0]  CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0]  CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0]  CH_MINUS  = 8'h2D;
  localparam logic [MAG_W-1:0] MAG_MAX   = 33'h1_FFFF_FFFF;
  localparam logic [MAG_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 33'h0_8000_0000;

endpackage

// ===== hdl/int_list_parse_validate.sv =====
// Top level of the integer list checker: parser, duplicate scan, value table.
// Depends on ilpv_pkg and assert_macros.svh.
//
//  channel | dir | tdata                        | tuser        | tlast
//  in_     | in  | ch [7:0]                     | op [1:0]     | -
//  out_    | out | value [31:0], position[41:32]| status [2:0] | last
//
// Character words are taken one per cycle while no scan runs. An
// end-of-number word finishes in the cycle it is accepted when the number is
// bad, out of range, a sticky error is set or the table is empty; otherwise
// it starts a scan of the value table through its single read port (one
// entry per cycle), which ends at the first duplicate or after the last entry.
// Reset clears the parser, the count and the sticky status; the table has no
// clearing pass, since only entries below the count are read. A stalled
// output holds the next end-of-number word and the scan result; characters
// keep flowing while a result waits.
`include "assert_macros.svh"

module int_list_parse_validate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch [7:0]
  input  logic [1:0]  in_tuser,   // op [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value [31:0], position [41:32], zero [47:42]
  output logic [2:0]  out_tuser,  // status [2:0]
  output logic        out_tlast   // last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // Control state
  logic                          state_r, state_nxt;
  logic [ilpv_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ilpv_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic                          cmpv_r, cmpv_nxt;
  ilpv_pkg::status_t             sticky_r, sticky_nxt;
  logic                          out_vld_r, out_vld_nxt;

  // Parser state
  logic [ilpv_pkg::MAG_W-1:0]    mag_r, mag_nxt;
  logic                          neg_r, neg_nxt;
  logic                          start_r, start_nxt;
  logic                          digit_r, digit_nxt;
  logic                          fault_r, fault_nxt;

  // Payload held during the scan and at the output
  logic [ilpv_pkg::VAL_W-1:0]    val_r, val_nxt;
  logic                          last_r, last_nxt;
  logic [ilpv_pkg::VAL_W-1:0]    out_val_r;
  ilpv_pkg::status_t             out_stat_r;
  logic [ilpv_pkg::POS_W-1:0]    out_pos_r;
  logic                          out_last_r;

  // Value table
  logic [ilpv_pkg::VAL_W-1:0]    mem [ilpv_pkg::MAX_NUMBERS];
  logic [ilpv_pkg::VAL_W-1:0]    rd_data_r;
  logic                          rd_en;
  logic [ilpv_pkg::IDX_W-1:0]    rd_addr;
  logic                          wr_en;

  // Working signals
  logic                          acc;
  logic                          is_end;
  logic                          out_free;
  logic                          is_digit;
  logic [ilpv_pkg::MAG_W+3:0]    mag_mul;
  logic [ilpv_pkg::CH_W-1:0]     digit_val;
  ilpv_pkg::status_t             pre_stat;
  logic [ilpv_pkg::VAL_W-1:0]    pre_val;
  logic                          hit;
  logic                          fin;
  ilpv_pkg::status_t             fin_raw;
  logic [ilpv_pkg::VAL_W-1:0]    fin_val;
  logic                          fin_last;
  ilpv_pkg::status_t             fin_stat;

  assign is_end   = (in_tuser == ilpv_pkg::OP_END) || (in_tuser == ilpv_pkg::OP_LAST);
  assign out_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && (!is_end || out_free);
  assign acc      = in_tvalid && in_tready;

  // Digit step: magnitude * 10 + digit, saturated
  assign is_digit  = (in_tdata >= ilpv_pkg::CH_ZERO) && (in_tdata <= ilpv_pkg::CH_NINE);
  assign digit_val = in_tdata - ilpv_pkg::CH_ZERO;
  assign mag_mul   = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1)
                   + (ilpv_pkg::MAG_W+4)'(digit_val);

  // Classify the finished number
  always_comb begin
    pre_stat = ilpv_pkg::ST_OK;
    pre_val  = '0;
    if (fault_r || !digit_r) begin
      pre_stat = ilpv_pkg::ST_BAD;
    end else if (neg_r ? (mag_r > ilpv_pkg::NEG_LIMIT) : (mag_r > ilpv_pkg::POS_LIMIT)) begin
      pre_stat = ilpv_pkg::ST_RANGE;
    end else if (neg_r) begin
      pre_val = '0 - mag_r[ilpv_pkg::VAL_W-1:0];
    end else begin
      pre_val = mag_r[ilpv_pkg::VAL_W-1:0];
    end
  end

  // Compare the entry read in the previous cycle
  assign hit = cmpv_r && (rd_data_r == val_r);

  // Sequencer: parse characters, start and run the table scan, finish
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmpv_nxt  = 1'b0;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    start_nxt = start_r;
    digit_nxt = digit_r;
    fault_nxt = fault_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[ilpv_pkg::IDX_W-1:0];
    fin       = 1'b0;
    fin_raw   = ilpv_pkg::ST_OK;
    fin_val   = val_r;
    fin_last  = last_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_tuser == ilpv_pkg::OP_CHAR) begin
          if (start_r && in_tdata == ilpv_pkg::CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (is_digit) begin
            mag_nxt   = (mag_mul > (ilpv_pkg::MAG_W+4)'(ilpv_pkg::MAG_MAX)) ?
                        ilpv_pkg::MAG_MAX : mag_mul[ilpv_pkg::MAG_W-1:0];
            digit_nxt = 1'b1;
          end else begin
            fault_nxt = 1'b1;
          end
          start_nxt = 1'b0;
        end else if (acc && is_end) begin
          // Clear the parser for the next number
          mag_nxt   = '0;
          neg_nxt   = 1'b0;
          start_nxt = 1'b1;
          digit_nxt = 1'b0;
          fault_nxt = 1'b0;
          val_nxt   = pre_val;
          last_nxt  = (in_tuser == ilpv_pkg::OP_LAST);
          if (sticky_r != ilpv_pkg::ST_OK || pre_stat != ilpv_pkg::ST_OK || cnt_r == '0) begin
            fin      = 1'b1;
            fin_raw  = pre_stat;
            fin_val  = pre_val;
            fin_last = (in_tuser == ilpv_pkg::OP_LAST);
          end else begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit || idx_r == cnt_r) begin
          // Finish once the output register can take the result
          if (out_free) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
            if (hit) begin
              fin_raw = ilpv_pkg::ST_DUP;
            end else if (cnt_r >= ilpv_pkg::CNT_W'(ilpv_pkg::MAX_NUMBERS)) begin
              fin_raw = ilpv_pkg::ST_FULL;
            end
          end else begin
            cmpv_nxt = cmpv_r;
          end
        end else begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          cmpv_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Apply the sticky status and decide whether to store
  always_comb begin
    fin_stat   = (sticky_r != ilpv_pkg::ST_OK) ? sticky_r : fin_raw;
    sticky_nxt = sticky_r;
    wr_en      = 1'b0;
    cnt_nxt    = cnt_r;
    if (fin && sticky_r == ilpv_pkg::ST_OK) begin
      if (fin_raw != ilpv_pkg::ST_OK) begin
        sticky_nxt = fin_raw;
      end else begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (fin) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Value table: one write and one registered read per cycle. A write lands
  // at the count, just above the stored entries, and the next scan reads it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ilpv_pkg::IDX_W-1:0]] <= fin_val;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      cmpv_r    <= 1'b0;
      sticky_r  <= ilpv_pkg::ST_OK;
      out_vld_r <= 1'b0;
      mag_r     <= '0;
      neg_r     <= 1'b0;
      start_r   <= 1'b1;
      digit_r   <= 1'b0;
      fault_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      cmpv_r    <= cmpv_nxt;
      sticky_r  <= sticky_nxt;
      out_vld_r <= out_vld_nxt;
      mag_r     <= mag_nxt;
      neg_r     <= neg_nxt;
      start_r   <= start_nxt;
      digit_r   <= digit_nxt;
      fault_r   <= fault_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
    if (fin) begin
      out_val_r  <= fin_val;
      out_stat_r <= fin_stat;
      out_pos_r  <= ilpv_pkg::POS_W'(cnt_r);
      out_last_r <= fin_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ilpv_pkg::OUT_DATA_W - ilpv_pkg::POS_W - ilpv_pkg::VAL_W){1'b0}},
                       out_pos_r, out_val_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // Checks on the count, the scan and the sticky status
  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= ilpv_pkg::CNT_W'(ilpv_pkg::MAX_NUMBERS), "count past table size")
  `ASSERT_ALWAYS(a_scan_clean, state_r != S_SCAN || sticky_r == ilpv_pkg::ST_OK, "scan with sticky error")
  `ASSERT_ALWAYS(a_store_ok, !wr_en || (sticky_r == ilpv_pkg::ST_OK && cnt_r < ilpv_pkg::CNT_W'(ilpv_pkg::MAX_NUMBERS)), "bad table write")
  `ASSERT_NEXT(a_sticky_hold, sticky_r != ilpv_pkg::ST_OK, $stable(sticky_r), "sticky status changed")
  `ASSERT_NEXT(a_idx_bound, state_r == S_SCAN, idx_r <= cnt_r, "scan index past count")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for int_list_parse_validate: directed and random number lists.
// Predicts each result word from its own parser and value table; depends on ilpv_pkg.
`timescale 1ns / 1ps

module tb_top;

  // Op 3 has no meaning in the block; the bench sends it as noise
  localparam ilpv_pkg::op_t OP_NONE = 2'd3;
  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  TAIL_CYCLES = ilpv_pkg::MAX_NUMBERS + 8;
  localparam int  PRINT_LIMIT = 30;
  localparam int  FILL_TARGET = 80;

  typedef struct {
    logic [ilpv_pkg::VAL_W-1:0] value;
    ilpv_pkg::status_t          status;
    logic [ilpv_pkg::POS_W-1:0] position;
    logic                       last;
  } number_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // ch [7:0]
  logic [1:0]  in_tuser;   // op [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // value [31:0], position [41:32], zero [47:42]
  logic [2:0]  out_tuser;  // status [2:0]
  logic        out_tlast;  // last

  // Parser state as the bench sees it
  logic [ilpv_pkg::MAG_W-1:0] acc_mag      = '0;
  logic                       acc_neg      = 1'b0;
  logic                       acc_at_start = 1'b1;
  logic                       acc_digit    = 1'b0;
  logic                       acc_fault    = 1'b0;
  logic [ilpv_pkg::VAL_W-1:0] seen_values[ilpv_pkg::MAX_NUMBERS];
  int                         seen_count   = 0;
  ilpv_pkg::status_t          first_error  = ilpv_pkg::ST_OK;

  number_result_t pending_numbers[$];

  int  fail_count      = 0;
  int  numbers_checked = 0;
  int  words_sent      = 0;
  int  cycle_count     = 0;
  int  hold_request    = 0;
  int  holds_done      = 0;
  int  drains_done     = 0;
  int  stall_left      = 0;
  bit  steady          = 1'b0;

  int_list_parse_validate dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // No gap while steady is set; else mostly none, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit value_stored(logic [ilpv_pkg::VAL_W-1:0] val);
    for (int k = 0; k < seen_count; k++)
      if (seen_values[k] == val) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the parser by one accepted word; queue the number it finishes
  function automatic void parse_word(ilpv_pkg::op_t op, logic [7:0] ch);
    logic [ilpv_pkg::MAG_W+3:0] grown;
    logic [ilpv_pkg::VAL_W-1:0] val;
    ilpv_pkg::status_t          st;
    number_result_t             res;
    val = '0;
    st  = ilpv_pkg::ST_OK;
    if (op == ilpv_pkg::OP_CHAR) begin
      if (acc_at_start && ch == ilpv_pkg::CH_MINUS) begin
        acc_neg = 1'b1;
      end else if (ch >= ilpv_pkg::CH_ZERO && ch <= ilpv_pkg::CH_NINE) begin
        grown     = acc_mag * 10 + (ch - ilpv_pkg::CH_ZERO);
        acc_mag   = (grown > ilpv_pkg::MAG_MAX) ? ilpv_pkg::MAG_MAX
                                                : grown[ilpv_pkg::MAG_W-1:0];
        acc_digit = 1'b1;
      end else begin
        acc_fault = 1'b1;
      end
      acc_at_start = 1'b0;
    end else if (op == ilpv_pkg::OP_END || op == ilpv_pkg::OP_LAST) begin
      if (acc_fault || !acc_digit) begin
        st = ilpv_pkg::ST_BAD;
      end else if (acc_neg ? acc_mag > ilpv_pkg::NEG_LIMIT : acc_mag > ilpv_pkg::POS_LIMIT) begin
        st = ilpv_pkg::ST_RANGE;
      end else begin
        val = acc_neg ? -acc_mag[ilpv_pkg::VAL_W-1:0] : acc_mag[ilpv_pkg::VAL_W-1:0];
        if (value_stored(val)) st = ilpv_pkg::ST_DUP;
        else if (seen_count >= ilpv_pkg::MAX_NUMBERS) st = ilpv_pkg::ST_FULL;
      end
      res.value    = val;
      res.position = ilpv_pkg::POS_W'(seen_count);
      res.last     = (op == ilpv_pkg::OP_LAST);
      // First error sticks; only clean numbers enter the table
      if (first_error != ilpv_pkg::ST_OK) begin
        st = first_error;
      end else if (st != ilpv_pkg::ST_OK) begin
        first_error = st;
      end else begin
        seen_values[seen_count] = val;
        seen_count++;
      end
      res.status = st;
      pending_numbers.push_back(res);
      acc_mag      = '0;
      acc_neg      = 1'b0;
      acc_at_start = 1'b1;
      acc_digit    = 1'b0;
      acc_fault    = 1'b0;
    end
  endfunction

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(ilpv_pkg::op_t op, logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    parse_word(op, ch);
    if (op != OP_NONE) words_sent++;
  endtask

  // Send a number's text, with the odd ignored word mixed in, then its end word
  task automatic send_text(string text, ilpv_pkg::op_t end_op);
    for (int i = 0; i < text.len(); i++) begin
      if ($urandom_range(0, 19) == 0) send_word(OP_NONE, 8'($urandom_range(0, 255)));
      send_word(ilpv_pkg::OP_CHAR, text[i]);
    end
    send_word(end_op, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    wait (pending_numbers.size() == 0);
    @(posedge clk);
    drains_done++;
  endtask

  function automatic ilpv_pkg::op_t pick_end_op();
    return ($urandom_range(0, 9) == 0) ? ilpv_pkg::OP_LAST : ilpv_pkg::OP_END;
  endfunction

  function automatic string number_text(bit neg, logic [ilpv_pkg::MAG_W-1:0] mag);
    string text;
    text = neg ? "-" : "";
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) text = {text, "0"};
    return {text, $sformatf("%0d", mag)};
  endfunction

  // Mostly short magnitudes, a few full-width and a few at the range limits
  function automatic logic [ilpv_pkg::MAG_W-1:0] pick_magnitude(bit neg);
    case ($urandom_range(0, 9))
      0:             return ilpv_pkg::MAG_W'($urandom_range(0, 9));
      1, 2, 3, 4, 5: return ilpv_pkg::MAG_W'($urandom_range(10, 9999));
      6, 7:          return ilpv_pkg::MAG_W'($urandom_range(10000, 99_999_999));
      8:             return ilpv_pkg::MAG_W'($urandom() >> 1);
      default:       return (neg ? ilpv_pkg::NEG_LIMIT : ilpv_pkg::POS_LIMIT)
                            - ilpv_pkg::MAG_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    // Keep the log short; every mismatch still counts
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    number_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("unexpected result, value", $signed(out_tdata[31:0]), 0);
      end else begin
        want = pending_numbers.pop_front();
        if (out_tdata[31:0] != want.value)
          report_mismatch("value", $signed(out_tdata[31:0]), $signed(want.value));
        if (out_tuser != want.status)
          report_mismatch("status", out_tuser, want.status);
        if (out_tdata[41:32] != want.position)
          report_mismatch("position", out_tdata[41:32], want.position);
        if (out_tlast != want.last)
          report_mismatch("last", out_tlast, want.last);
        numbers_checked++;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Clean extremes first, so the table keeps filling afterwards
  task automatic test_directed_values();
    send_text("-0", ilpv_pkg::OP_END);
    send_text("2147483647", ilpv_pkg::OP_END);
    send_text("-2147483648", ilpv_pkg::OP_END);
    send_word(ilpv_pkg::OP_CHAR, "4");
    send_word(OP_NONE, 8'hFF);
    send_word(ilpv_pkg::OP_CHAR, "2");
    send_word(ilpv_pkg::OP_LAST, 8'h00);
    send_text("-07", ilpv_pkg::OP_END);
  endtask

  // Grow the table with unique well-formed numbers under output pressure
  task automatic test_fill_table();
    bit                         neg;
    logic [ilpv_pkg::MAG_W-1:0] mag;
    while (seen_count < FILL_TARGET) begin
      if (seen_count == 20) hold_request = 300;
      if (seen_count == 50) wait_drained();
      steady = (seen_count >= 30 && seen_count < 40);
      do begin
        neg = 1'($urandom_range(0, 1));
        mag = pick_magnitude(neg);
      end while (value_stored(neg ? -mag[ilpv_pkg::VAL_W-1:0] : mag[ilpv_pkg::VAL_W-1:0]));
      send_text(number_text(neg, mag), pick_end_op());
    end
    steady = 1'b0;
  endtask

  // A duplicate stops the clean run; bad characters, empty numbers and range
  // follow under the sticky status
  task automatic test_error_cases();
    send_text("-2147483648", ilpv_pkg::OP_END);
    send_text("+5", ilpv_pkg::OP_END);
    send_text("/3", ilpv_pkg::OP_END);
    send_text(":1", ilpv_pkg::OP_END);
    send_text("1-2", ilpv_pkg::OP_END);
    send_text("--1", ilpv_pkg::OP_END);
    send_text("", ilpv_pkg::OP_END);
    send_text("-", ilpv_pkg::OP_LAST);
    send_text("99999999999999999999", ilpv_pkg::OP_END);
    send_text("2147483648", ilpv_pkg::OP_END);
    send_text("-2147483649", ilpv_pkg::OP_END);
    send_text("0", ilpv_pkg::OP_END);
  endtask

  // Mostly numbers with random content, the rest raw words of any op and byte
  task automatic test_random_words(int count);
    int         stop;
    bit         neg;
    logic [7:0] ch;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(0, 9) < 6) begin
        neg = 1'($urandom_range(0, 1));
        send_text(number_text(neg, ($urandom_range(0, 7) == 0) ?
                  {1'($urandom_range(0, 1)), $urandom()} : pick_magnitude(neg)),
                  pick_end_op());
      end else begin
        case ($urandom_range(0, 7))
          0:       ch = ilpv_pkg::CH_MINUS;
          1:       ch = ilpv_pkg::CH_ZERO - 8'd1;
          2:       ch = ilpv_pkg::CH_NINE + 8'd1;
          3:       ch = 8'($urandom_range(ilpv_pkg::CH_ZERO, ilpv_pkg::CH_NINE));
          default: ch = 8'($urandom_range(0, 255));
        endcase
        send_word(ilpv_pkg::op_t'($urandom_range(0, 3)), ch);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ilpv_pkg::OP_CHAR;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_values();
    test_fill_table();
    test_error_cases();
    test_random_words(280);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d words and %0d checked numbers; table filled to %0d of %0d.",
             words_sent, numbers_checked, seen_count, ilpv_pkg::MAX_NUMBERS);
    $display("Output held off %0d time(s), input drained %0d time(s), sticky status %0d.",
             holds_done, drains_done, first_error);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== int_list_parse_validate.f =====
+incdir+hdl
hdl/ilpv_pkg.sv
hdl/int_list_parse_validate.sv
test/tb_top.sv
